>>> sv/voxel_ray_traversal_dda_assert.svh
// assertion macros for the ray walker checker
`ifndef VOXEL_RAY_TRAVERSAL_DDA_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_DDA_ASSERT_SVH
// a condition implies another in the same cycle
`define VRT_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// a condition implies another in the next cycle
`define VRT_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> sv/vrt_pkg.sv
package vrt_pkg;
  localparam int CELL_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [1:0] RK_PROBE = 2'd0;
  localparam logic [1:0] RK_HIT = 2'd1;
  localparam logic [1:0] RK_MISS = 2'd2;
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_DIVSET, ST_DIV, ST_DIVEND, ST_OUT, ST_WAIT, ST_STEP
  } state_t;
endpackage

>>> sv/voxel_ray_traversal_dda.sv
// voxel ray walker, 3d dda over a cell grid
// input channel (in_valid/in_ready): kind 0 starts a ray with origin,
// direction and reach; kind 1 answers the last probe with in_solid.
// output channel (out_valid/out_ready): a probe for a cell, a hit with the
// cell and the previous cell, or a miss with the distance reached.
// a start runs a setup on one shared subtractor: a restoring square root
// (two radicand bits and one root bit per cycle), then six restoring
// divisions (two per axis, each loaded in ST_DIVSET, taken through 64
// quotient steps in ST_DIV and closed in ST_DIVEND; an axis whose direction
// component is zero skips ST_DIV). the first probe is registered in ST_OUT
// after the last division; a zero direction or a negative reach gives the
// miss in the next cycle.
// a non-solid answer passes through the ST_STEP compare-and-add state, which
// registers the next probe or a miss; a hit is valid in the next cycle.
// in_ready is high only while waiting for a start or for an answer and no
// result is pending; an answer while idle is dropped without a result.
// a stalled receiver holds the result in the output register and the block
// accepts nothing until it is taken.
// reset (rst_n low, synchronous) returns to idle with no pending result.
module voxel_ray_traversal_dda #(
  parameter int CELL_BITS = vrt_pkg::CELL_BITS_DEF,
  parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic signed [31:0] in_reach,
  input  logic               in_solid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic signed [15:0] out_cell_x,
  output logic signed [15:0] out_cell_y,
  output logic signed [15:0] out_cell_z,
  output logic signed [15:0] out_prev_x,
  output logic signed [15:0] out_prev_y,
  output logic signed [15:0] out_prev_z,
  output logic [31:0]        out_travelled
);
  localparam int NW = 64;   // dividend width: r*len < 2^(FRAC_BITS+18)
  localparam int QB = 33;   // quotient bits kept before saturation

  vrt_pkg::state_t st_r, st_nxt;
  logic busy_r, busy_nxt;
  logic [CELL_BITS-1:0] cur_r [3], cur_nxt [3];
  logic [CELL_BITS-1:0] prv_r [3], prv_nxt [3];
  logic [2:0] neg_r, neg_nxt;
  logic [15:0] mag_r [3], mag_nxt [3];
  logic [31:0] bd_r [3], bd_nxt [3];
  logic [31:0] sp_r [3], sp_nxt [3];
  logic [FRAC_BITS-1:0] frac_r [3], frac_nxt [3];
  logic [31:0] reach_r, reach_nxt;
  // shared iterative unit state
  logic [31:0] sum_r, sum_nxt;        // radicand remainder
  logic [16:0] root_r, root_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [2:0] job_r, job_nxt;          // division job: axis*2 + span
  logic [NW-1:0] num_r, num_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [QB-1:0] quo_r, quo_nxt;
  // output register
  logic ov_r, ov_nxt;
  logic [1:0] ok_r, ok_nxt;
  logic [15:0] oc_r [3], oc_nxt [3];
  logic [15:0] op_r [3], op_nxt [3];
  logic [31:0] ot_r, ot_nxt;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;
  assign in_ready = !ov_r && (st_r == vrt_pkg::ST_IDLE || st_r == vrt_pkg::ST_WAIT);

  logic signed [31:0] org [3];
  logic signed [15:0] dir [3];
  assign org[0] = in_origin_x; assign org[1] = in_origin_y; assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x; assign dir[1] = in_dir_y; assign dir[2] = in_dir_z;

  // shared subtractor for root and division steps
  logic [33:0] sub_a, sub_b, sub_d;
  logic sub_ok;
  assign sub_d = sub_a - sub_b;
  assign sub_ok = sub_a >= sub_b;

  logic [15:0] dmag;
  logic [1:0] ax;
  logic [31:0] dsel;
  logic [31:0] dsum;
  logic [32:0] dsum_w;
  logic [1:0] sel;
  logic [33:0] sq_acc;
  logic [15:0] mg;
  logic [31:0] sqv;
  logic [FRAC_BITS:0] rsel;
  logic [FRAC_BITS+17:0] prod;

  function automatic logic [31:0] qsat_f(input logic [QB-1:0] q, input logic b);
    logic [QB-1:0] qn;
    qn = q[QB-1] ? q : {q[QB-2:0], b};
    return qn[QB-1] ? vrt_pkg::ALL_ONES : qn[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vrt_pkg::ST_IDLE;
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
    end
    cur_r <= cur_nxt; prv_r <= prv_nxt; neg_r <= neg_nxt; mag_r <= mag_nxt;
    bd_r <= bd_nxt; sp_r <= sp_nxt; frac_r <= frac_nxt; reach_r <= reach_nxt;
    sum_r <= sum_nxt; root_r <= root_nxt; cnt_r <= cnt_nxt; job_r <= job_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    ok_r <= ok_nxt; oc_r <= oc_nxt; op_r <= op_nxt; ot_r <= ot_nxt;
  end

  always_comb begin
    st_nxt = st_r; busy_nxt = busy_r;
    cur_nxt = cur_r; prv_nxt = prv_r; neg_nxt = neg_r; mag_nxt = mag_r;
    bd_nxt = bd_r; sp_nxt = sp_r; frac_nxt = frac_r; reach_nxt = reach_r;
    sum_nxt = sum_r; root_nxt = root_r; cnt_nxt = cnt_r; job_nxt = job_r;
    num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r;
    ov_nxt = ov_r; ok_nxt = ok_r; oc_nxt = oc_r; op_nxt = op_r; ot_nxt = ot_r;
    sub_a = '0; sub_b = '0;
    ax = job_r[2:1];
    dmag = mag_r[ax];
    sq_acc = '0;
    mg = '0; sqv = '0;
    rsel = '0; prod = '0;
    sel = 2'd0; dsel = '0; dsum_w = '0; dsum = '0;

    if (out_valid && out_ready) ov_nxt = 1'b0;

    case (st_r)
      vrt_pkg::ST_SQRT: begin
        // restoring root, two radicand bits per cycle
        sub_a = {sum_r, num_r[NW-1 -: 2]};
        sub_b = {15'd0, root_r, 2'b01};
        num_nxt = num_r << 2;
        if (sub_ok) begin
          sum_nxt = sub_d[31:0]; root_nxt = {root_r[15:0], 1'b1};
        end else begin
          sum_nxt = sub_a[31:0]; root_nxt = {root_r[15:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          job_nxt = 3'd0;
          st_nxt = vrt_pkg::ST_DIVSET;
        end
      end
      vrt_pkg::ST_DIVSET: begin
        if (dmag == 16'd0) begin
          if (job_r[0]) sp_nxt[ax] = vrt_pkg::ALL_ONES;
          else bd_nxt[ax] = vrt_pkg::ALL_ONES;
          st_nxt = vrt_pkg::ST_DIVEND;
        end else begin
          // dividend = r * len, product kept narrow: r <= 2^FRAC_BITS, len < 2^17
          if (job_r[0]) rsel = {1'b1, {FRAC_BITS{1'b0}}};
          else if (neg_r[ax]) rsel = {1'b0, frac_r[ax]};
          else rsel = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_r[ax]};
          prod = rsel * root_r;
          num_nxt = NW'(prod);
          rem_nxt = '0; quo_nxt = '0;
          cnt_nxt = 6'(NW - 1);
          st_nxt = vrt_pkg::ST_DIV;
        end
      end
      vrt_pkg::ST_DIV: begin
        sub_a = {17'd0, rem_r, num_r[NW-1]};
        sub_b = {18'd0, dmag};
        num_nxt = num_r << 1;
        if (sub_ok) rem_nxt = sub_d[15:0]; else rem_nxt = sub_a[15:0];
        quo_nxt = (quo_r[QB-1] ? quo_r : {quo_r[QB-2:0], sub_ok});
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (job_r[0]) sp_nxt[ax] = qsat_f(quo_r, sub_ok);
          else bd_nxt[ax] = qsat_f(quo_r, sub_ok);
          st_nxt = vrt_pkg::ST_DIVEND;
        end
      end
      vrt_pkg::ST_DIVEND: begin
        if (job_r == 3'd5) begin
          st_nxt = vrt_pkg::ST_OUT;
        end else begin
          job_nxt = job_r + 3'd1;
          st_nxt = vrt_pkg::ST_DIVSET;
        end
      end
      vrt_pkg::ST_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; ok_nxt = vrt_pkg::RK_PROBE; ot_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            oc_nxt[i] = 16'(cur_r[i]); op_nxt[i] = '0;
          end
          busy_nxt = 1'b1;
          st_nxt = vrt_pkg::ST_WAIT;
        end
      end
      vrt_pkg::ST_STEP: begin
        if (bd_r[0] <= bd_r[1] && bd_r[0] <= bd_r[2]) sel = 2'd0;
        else if (bd_r[1] <= bd_r[2]) sel = 2'd1;
        else sel = 2'd2;
        dsel = bd_r[sel];
        dsum_w = {1'b0, dsel} + {1'b0, sp_r[sel]};
        dsum = dsum_w[32] ? vrt_pkg::ALL_ONES : dsum_w[31:0];
        prv_nxt = cur_r;
        if (mag_r[sel] != 16'd0)
          cur_nxt[sel] = neg_r[sel] ? cur_r[sel] - 1'b1 : cur_r[sel] + 1'b1;
        bd_nxt[sel] = dsum;
        ot_nxt = dsel;
        ov_nxt = 1'b1;
        if (dsel > reach_r) begin
          ok_nxt = vrt_pkg::RK_MISS; busy_nxt = 1'b0;
          for (int i = 0; i < 3; i++) begin oc_nxt[i] = '0; op_nxt[i] = '0; end
          st_nxt = vrt_pkg::ST_IDLE;
        end else begin
          ok_nxt = vrt_pkg::RK_PROBE;
          for (int i = 0; i < 3; i++) begin
            oc_nxt[i] = 16'(cur_nxt[i]); op_nxt[i] = '0;
          end
          st_nxt = vrt_pkg::ST_WAIT;
        end
      end
      default: ;
    endcase

    if (in_xfer) begin
      if (in_kind == vrt_pkg::KIND_START) begin
        busy_nxt = 1'b0;
        for (int i = 0; i < 3; i++) begin
          mg = dir[i][15] ? 16'(-dir[i]) : dir[i];
          mag_nxt[i] = mg;
          neg_nxt[i] = dir[i][15];
          sqv = 32'(mg) * 32'(mg);
          sq_acc = sq_acc + 34'(sqv);
          frac_nxt[i] = org[i][FRAC_BITS-1:0];
          cur_nxt[i] = CELL_BITS'(org[i] >>> FRAC_BITS);
          prv_nxt[i] = CELL_BITS'(org[i] >>> FRAC_BITS);
        end
        reach_nxt = in_reach;
        if (sq_acc == '0 || in_reach[31]) begin
          ov_nxt = 1'b1; ok_nxt = vrt_pkg::RK_MISS; ot_nxt = '0;
          for (int i = 0; i < 3; i++) begin oc_nxt[i] = '0; op_nxt[i] = '0; end
          st_nxt = vrt_pkg::ST_IDLE;
        end else begin
          num_nxt = {sq_acc, 30'd0};
          sum_nxt = '0; root_nxt = '0;
          cnt_nxt = 6'd16;
          st_nxt = vrt_pkg::ST_SQRT;
        end
      end else if (busy_r) begin
        if (in_solid) begin
          ov_nxt = 1'b1; ok_nxt = vrt_pkg::RK_HIT; busy_nxt = 1'b0;
          for (int i = 0; i < 3; i++) begin
            oc_nxt[i] = 16'(cur_r[i]); op_nxt[i] = 16'(prv_r[i]);
          end
          st_nxt = vrt_pkg::ST_IDLE;
        end else begin
          st_nxt = vrt_pkg::ST_STEP;
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_result_kind = ok_r;
  assign out_cell_x = oc_r[0]; assign out_cell_y = oc_r[1]; assign out_cell_z = oc_r[2];
  assign out_prev_x = op_r[0]; assign out_prev_y = op_r[1]; assign out_prev_z = op_r[2];
  assign out_travelled = ot_r;
endmodule

>>> sv/vrt_checker.sv
`include "voxel_ray_traversal_dda_assert.svh"
module vrt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_result_kind,
  input logic [31:0] out_travelled
);
  logic out_stall;
  logic end_xfer;
  assign out_stall = out_valid && !out_ready;
  assign end_xfer = out_valid && out_ready && out_result_kind != vrt_pkg::RK_PROBE;

  `VRT_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `VRT_ASSERT_IMP(a_kind_legal, clk, rst_n, out_valid, out_result_kind <= vrt_pkg::RK_MISS)
  `VRT_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, out_valid && $stable(out_result_kind))
  `VRT_ASSERT_NEXT(a_dist_hold, clk, rst_n, out_stall, $stable(out_travelled))
  `VRT_ASSERT_NEXT(a_hit_idle, clk, rst_n, end_xfer, !out_valid)
endmodule

bind voxel_ray_traversal_dda vrt_checker u_vrt_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_result_kind(out_result_kind), .out_travelled(out_travelled)
);
